[sv/lom_pkg.sv]
// lom_pkg: result kinds and matcher state encoding for the limit order matcher
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package lom_pkg;

   typedef enum logic [1:0] {
      KIND_TRADE   = 2'd0,
      KIND_RESTED  = 2'd1,
      KIND_FILLED  = 2'd2,
      KIND_DROPPED = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_MATCH = 2'd1,
      ST_REST  = 2'd2
   } state_type;

   // command from the sequencer to every cell of one side
   typedef struct packed {
      logic pop;     // best entry leaves, all shift toward head
      logic dec;     // head quantity reduced by the fill
      logic insert;  // sorted insert of the incoming order
   } cell_cmd_type;

endpackage
`default_nettype wire

[sv/lom_cell.sv]
// lom_cell: one slot of a book side; holds one resting order
// depends on lom_pkg; neighbors chained in lom_book
`timescale 1ns / 1ps
`default_nettype none
module lom_cell import lom_pkg::*; #(
   parameter int PRICE_BITS = 16,
   parameter int QTY_BITS   = 24,
   parameter int ID_BITS    = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cell_cmd_type          cmd,
   input  wire logic                  is_ask,
   input  wire logic [QTY_BITS-1:0]   fill_qty,
   input  wire logic [PRICE_BITS-1:0] new_price,
   input  wire logic [QTY_BITS-1:0]   new_qty,
   input  wire logic [ID_BITS-1:0]    new_id,
   // neighbor toward head
   input  wire logic                  prev_valid,
   input  wire logic                  prev_ahead,
   input  wire logic [PRICE_BITS-1:0] prev_price,
   input  wire logic [QTY_BITS-1:0]   prev_qty,
   input  wire logic [ID_BITS-1:0]    prev_id,
   // neighbor toward tail
   input  wire logic                  next_valid,
   input  wire logic [PRICE_BITS-1:0] next_price,
   input  wire logic [QTY_BITS-1:0]   next_qty,
   input  wire logic [ID_BITS-1:0]    next_id,
   input  wire logic                  is_head,
   output logic                       valid,
   output logic                       ahead,
   output logic [PRICE_BITS-1:0]      price,
   output logic [QTY_BITS-1:0]        qty,
   output logic [ID_BITS-1:0]         id
);
   logic valid_ff, valid_in;
   logic [PRICE_BITS-1:0] price_ff, price_in;
   logic [QTY_BITS-1:0] qty_ff, qty_in;
   logic [ID_BITS-1:0] id_ff, id_in;

   // entry stays ahead of the new order: equal or better price
   assign ahead = valid_ff &&
                  (is_ask ? (price_ff <= new_price) : (price_ff >= new_price));

   always_comb begin
      valid_in = valid_ff;
      price_in = price_ff;
      qty_in   = qty_ff;
      id_in    = id_ff;
      if (cmd.pop) begin
         valid_in = next_valid;
         price_in = next_price;
         qty_in   = next_qty;
         id_in    = next_id;
      end else if (cmd.dec) begin
         if (is_head) qty_in = qty_ff - fill_qty;
      end else if (cmd.insert) begin
         if (!ahead) begin
            if ((is_head || prev_ahead) && (is_head || prev_valid)) begin
               valid_in = 1'b1;
               price_in = new_price;
               qty_in   = new_qty;
               id_in    = new_id;
            end else if (is_head) begin
               valid_in = 1'b1;
               price_in = new_price;
               qty_in   = new_qty;
               id_in    = new_id;
            end else begin
               valid_in = prev_valid;
               price_in = prev_price;
               qty_in   = prev_qty;
               id_in    = prev_id;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
      price_ff <= price_in;
      qty_ff   <= qty_in;
      id_ff    <= id_in;
   end

   assign valid = valid_ff;
   assign price = price_ff;
   assign qty   = qty_ff;
   assign id    = id_ff;
endmodule
`default_nettype wire

[sv/lom_book.sv]
// lom_book: one side of the book as a sorted chain of lom_cell slots
// depends on lom_pkg and lom_cell
`timescale 1ns / 1ps
`default_nettype none
module lom_book import lom_pkg::*; #(
   parameter int DEPTH      = 32,
   parameter int PRICE_BITS = 16,
   parameter int QTY_BITS   = 24,
   parameter int ID_BITS    = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  is_ask,
   input  wire cell_cmd_type          cmd,
   input  wire logic [QTY_BITS-1:0]   fill_qty,
   input  wire logic [PRICE_BITS-1:0] new_price,
   input  wire logic [QTY_BITS-1:0]   new_qty,
   input  wire logic [ID_BITS-1:0]    new_id,
   output logic                       head_valid,
   output logic [PRICE_BITS-1:0]      head_price,
   output logic [QTY_BITS-1:0]        head_qty,
   output logic [ID_BITS-1:0]         head_id,
   output logic                       full
);
   logic [DEPTH-1:0] v, a;
   logic [PRICE_BITS-1:0] p [DEPTH];
   logic [QTY_BITS-1:0] q [DEPTH];
   logic [ID_BITS-1:0] d [DEPTH];

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      localparam int PI = (i == 0) ? 0 : i - 1;
      localparam int NI = (i == DEPTH - 1) ? i : i + 1;
      lom_cell #(.PRICE_BITS(PRICE_BITS), .QTY_BITS(QTY_BITS), .ID_BITS(ID_BITS)) u_cell (
         .clock(clock), .reset(reset), .cmd(cmd), .is_ask(is_ask),
         .fill_qty(fill_qty), .new_price(new_price), .new_qty(new_qty), .new_id(new_id),
         .prev_valid(v[PI]), .prev_ahead(a[PI]),
         .prev_price(p[PI]), .prev_qty(q[PI]), .prev_id(d[PI]),
         .next_valid((i == DEPTH - 1) ? 1'b0 : v[NI]),
         .next_price(p[NI]), .next_qty(q[NI]), .next_id(d[NI]),
         .is_head(i == 0),
         .valid(v[i]), .ahead(a[i]), .price(p[i]), .qty(q[i]), .id(d[i])
      );
   end

   assign head_valid = v[0];
   assign head_price = p[0];
   assign head_qty   = q[0];
   assign head_id    = d[0];
   assign full       = v[DEPTH-1];
endmodule
`default_nettype wire

[sv/limit_order_matcher.sv]
// limit_order_matcher: price-time priority limit order book, top level
// depends on lom_pkg, lom_book (chain of lom_cell)
//
//  channel   handshake        payload
//  req_      start / busy     req_is_sell req_order_id req_order_price req_order_qty
//  rsp_      rsp_valid strobe rsp_kind rsp_buy_id rsp_sell_id rsp_trade_price
//                             rsp_trade_qty rsp_remaining_qty rsp_last
//
// an order takes one match step per fill (head compare, fill, pop or decrement)
// plus a closing step for the status transaction and the sorted insert, which
// happen in the same cycle; the status strobe comes after the last trade and busy
// is low during it, so the next order can be accepted while it is strobed
// the insert is a parallel shift across the cell chain
// reset clears the valid bit of every cell; the receiver cannot stall
`timescale 1ns / 1ps
`default_nettype none
module limit_order_matcher import lom_pkg::*; #(
   parameter int DEPTH_PER_SIDE = 32,
   parameter int PRICE_BITS     = 16,
   parameter int QTY_BITS       = 24,
   parameter int ID_BITS        = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic        req_is_sell,
   input  wire logic [31:0] req_order_id,
   input  wire logic [15:0] req_order_price,
   input  wire logic [23:0] req_order_qty,
   output logic             rsp_valid,
   output logic [1:0]       rsp_kind,
   output logic [31:0]      rsp_buy_id,
   output logic [31:0]      rsp_sell_id,
   output logic [15:0]      rsp_trade_price,
   output logic [23:0]      rsp_trade_qty,
   output logic [23:0]      rsp_remaining_qty,
   output logic             rsp_last
);
   state_type state_ff, state_in;

   // latched incoming order
   logic                  sell_ff;
   logic [ID_BITS-1:0]    id_ff;
   logic [PRICE_BITS-1:0] price_ff;
   logic [QTY_BITS-1:0]   qty_ff, qty_in;

   // result register
   logic        rv_ff, rv_in;
   logic [1:0]  rk_ff, rk_in;
   logic [31:0] rb_ff, rb_in, rs_ff, rs_in;
   logic [15:0] rp_ff, rp_in;
   logic [23:0] rt_ff, rt_in, rr_ff, rr_in;
   logic        rl_ff, rl_in;

   cell_cmd_type bid_cmd, ask_cmd;
   logic bid_hv, ask_hv, bid_full, ask_full;
   logic [PRICE_BITS-1:0] bid_hp, ask_hp;
   logic [QTY_BITS-1:0] bid_hq, ask_hq;
   logic [ID_BITS-1:0] bid_hd, ask_hd;

   // opposite side head
   logic                  o_hv;
   logic [PRICE_BITS-1:0] o_hp;
   logic [QTY_BITS-1:0]   o_hq, fill;
   logic [ID_BITS-1:0]    o_hd;
   logic                  crosses, do_fill, own_full;

   wire accept = start && !busy;

   assign o_hv = sell_ff ? bid_hv : ask_hv;
   assign o_hp = sell_ff ? bid_hp : ask_hp;
   assign o_hq = sell_ff ? bid_hq : ask_hq;
   assign o_hd = sell_ff ? bid_hd : ask_hd;
   assign own_full = sell_ff ? ask_full : bid_full;
   assign crosses = sell_ff ? (o_hp >= price_ff) : (o_hp <= price_ff);
   // at most DEPTH fills can happen since the side holds at most DEPTH
   assign do_fill = (qty_ff != '0) && o_hv && crosses;
   assign fill = (qty_ff < o_hq) ? qty_ff : o_hq;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (accept) state_in = ST_MATCH;
         ST_MATCH: if (!do_fill) state_in = ST_IDLE;
         ST_REST:  state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs and book commands
   always_comb begin
      bid_cmd = '0;
      ask_cmd = '0;
      qty_in = qty_ff;
      rv_in = 1'b0;
      rk_in = KIND_TRADE;
      rb_in = 32'(id_ff);
      rs_in = 32'(id_ff);
      rp_in = 16'(price_ff);
      rt_in = '0;
      rr_in = 24'(qty_ff);
      rl_in = 1'b0;
      case (state_ff)
         ST_MATCH: begin
            rv_in = 1'b1;
            if (do_fill) begin
               qty_in = qty_ff - fill;
               rk_in = KIND_TRADE;
               rb_in = sell_ff ? 32'(o_hd) : 32'(id_ff);
               rs_in = sell_ff ? 32'(id_ff) : 32'(o_hd);
               rp_in = 16'(o_hp);
               rt_in = 24'(fill);
               rr_in = 24'(qty_ff - fill);
               if (fill == o_hq) begin
                  if (sell_ff) bid_cmd.pop = 1'b1;
                  else ask_cmd.pop = 1'b1;
               end else begin
                  if (sell_ff) bid_cmd.dec = 1'b1;
                  else ask_cmd.dec = 1'b1;
               end
            end else begin
               rl_in = 1'b1;
               if (qty_ff == '0) rk_in = KIND_FILLED;
               else if (own_full) rk_in = KIND_DROPPED;
               else begin
                  rk_in = KIND_RESTED;
                  if (sell_ff) ask_cmd.insert = 1'b1;
                  else bid_cmd.insert = 1'b1;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rv_ff <= rv_in;
      end
      if (accept) begin
         sell_ff  <= req_is_sell;
         id_ff    <= req_order_id[ID_BITS-1:0];
         price_ff <= req_order_price[PRICE_BITS-1:0];
         qty_ff   <= req_order_qty[QTY_BITS-1:0];
      end else begin
         qty_ff <= qty_in;
      end
      rk_ff <= rk_in;
      rb_ff <= rb_in;
      rs_ff <= rs_in;
      rp_ff <= rp_in;
      rt_ff <= rt_in;
      rr_ff <= rr_in;
      rl_ff <= rl_in;
   end

   lom_book #(.DEPTH(DEPTH_PER_SIDE), .PRICE_BITS(PRICE_BITS), .QTY_BITS(QTY_BITS),
              .ID_BITS(ID_BITS)) u_bids (
      .clock(clock), .reset(reset), .is_ask(1'b0), .cmd(bid_cmd), .fill_qty(fill),
      .new_price(price_ff), .new_qty(qty_ff), .new_id(id_ff),
      .head_valid(bid_hv), .head_price(bid_hp), .head_qty(bid_hq), .head_id(bid_hd),
      .full(bid_full)
   );

   lom_book #(.DEPTH(DEPTH_PER_SIDE), .PRICE_BITS(PRICE_BITS), .QTY_BITS(QTY_BITS),
              .ID_BITS(ID_BITS)) u_asks (
      .clock(clock), .reset(reset), .is_ask(1'b1), .cmd(ask_cmd), .fill_qty(fill),
      .new_price(price_ff), .new_qty(qty_ff), .new_id(id_ff),
      .head_valid(ask_hv), .head_price(ask_hp), .head_qty(ask_hq), .head_id(ask_hd),
      .full(ask_full)
   );

   // busy until the status transaction is strobed; low during the strobe itself
   assign busy = (state_ff != ST_IDLE) || (rv_ff && !rl_ff);

   assign rsp_valid         = rv_ff;
   assign rsp_kind          = rk_ff;
   assign rsp_buy_id        = rb_ff;
   assign rsp_sell_id       = rs_ff;
   assign rsp_trade_price   = rp_ff;
   assign rsp_trade_qty     = rt_ff;
   assign rsp_remaining_qty = rr_ff;
   assign rsp_last          = rl_ff;
endmodule
`default_nettype wire

[tb/sv/tb_top.sv]
// tb_top: self-checking testbench for limit_order_matcher
// depends on lom_pkg and the limit_order_matcher rtl; predicts every trade and status
`timescale 1ns / 1ps
module tb_top;
   import lom_pkg::*;

   localparam int BOOK_DEPTH = 32;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] buy_id;
      logic [31:0] sell_id;
      logic [15:0] price;
      logic [23:0] trade_qty;
      logic [23:0] remaining;
      logic        last;
   } fill_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_is_sell = 1'b0;
   logic [31:0] req_order_id = '0;
   logic [15:0] req_order_price = '0;
   logic [23:0] req_order_qty = '0;
   logic        rsp_valid;
   logic [1:0]  rsp_kind;
   logic [31:0] rsp_buy_id;
   logic [31:0] rsp_sell_id;
   logic [15:0] rsp_trade_price;
   logic [23:0] rsp_trade_qty;
   logic [23:0] rsp_remaining_qty;
   logic        rsp_last;

   // predicted book: index 0 of each side is the best price
   logic [15:0] bids_price[BOOK_DEPTH];
   logic [23:0] bids_qty[BOOK_DEPTH];
   logic [31:0] bids_id[BOOK_DEPTH];
   int          bids_count = 0;
   logic [15:0] asks_price[BOOK_DEPTH];
   logic [23:0] asks_qty[BOOK_DEPTH];
   logic [31:0] asks_id[BOOK_DEPTH];
   int          asks_count = 0;

   fill_type    pending_fills[$];
   int          error_count = 0;
   int          idle_count = 0;
   int          send_gap_pct = 0;

   limit_order_matcher dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_is_sell(req_is_sell), .req_order_id(req_order_id),
      .req_order_price(req_order_price), .req_order_qty(req_order_qty),
      .rsp_valid(rsp_valid), .rsp_kind(rsp_kind), .rsp_buy_id(rsp_buy_id),
      .rsp_sell_id(rsp_sell_id), .rsp_trade_price(rsp_trade_price),
      .rsp_trade_qty(rsp_trade_qty), .rsp_remaining_qty(rsp_remaining_qty),
      .rsp_last(rsp_last)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
      error_count++;
   endtask

   // predict all trades and the closing status for one order
   task automatic match_order(input logic sell, input logic [31:0] oid,
                              input logic [15:0] price, input logic [23:0] qty_in);
      logic [23:0] qty;
      logic [23:0] fill;
      int          pos;
      int          n;
      qty = qty_in;
      n = 0;
      if (sell) begin
         while (qty > 0 && bids_count > 0 && n < BOOK_DEPTH && bids_price[0] >= price) begin
            fill = (qty < bids_qty[0]) ? qty : bids_qty[0];
            qty -= fill;
            bids_qty[0] -= fill;
            pending_fills.push_back('{KIND_TRADE, bids_id[0], oid, bids_price[0], fill, qty, 1'b0});
            n++;
            if (bids_qty[0] == 0) begin
               for (int i = 1; i < bids_count; i++) begin
                  bids_price[i-1] = bids_price[i];
                  bids_qty[i-1] = bids_qty[i];
                  bids_id[i-1] = bids_id[i];
               end
               bids_count--;
            end
         end
      end else begin
         while (qty > 0 && asks_count > 0 && n < BOOK_DEPTH && asks_price[0] <= price) begin
            fill = (qty < asks_qty[0]) ? qty : asks_qty[0];
            qty -= fill;
            asks_qty[0] -= fill;
            pending_fills.push_back('{KIND_TRADE, oid, asks_id[0], asks_price[0], fill, qty, 1'b0});
            n++;
            if (asks_qty[0] == 0) begin
               for (int i = 1; i < asks_count; i++) begin
                  asks_price[i-1] = asks_price[i];
                  asks_qty[i-1] = asks_qty[i];
                  asks_id[i-1] = asks_id[i];
               end
               asks_count--;
            end
         end
      end
      if (qty == 0) begin
         pending_fills.push_back('{KIND_FILLED, oid, oid, price, 24'd0, qty, 1'b1});
      end else if ((sell ? asks_count : bids_count) >= BOOK_DEPTH) begin
         pending_fills.push_back('{KIND_DROPPED, oid, oid, price, 24'd0, qty, 1'b1});
      end else begin
         // rest behind every order of equal or better price
         pos = 0;
         if (sell) begin
            while (pos < asks_count && asks_price[pos] <= price) pos++;
            for (int i = asks_count; i > pos; i--) begin
               asks_price[i] = asks_price[i-1];
               asks_qty[i] = asks_qty[i-1];
               asks_id[i] = asks_id[i-1];
            end
            asks_price[pos] = price; asks_qty[pos] = qty; asks_id[pos] = oid;
            asks_count++;
         end else begin
            while (pos < bids_count && bids_price[pos] >= price) pos++;
            for (int i = bids_count; i > pos; i--) begin
               bids_price[i] = bids_price[i-1];
               bids_qty[i] = bids_qty[i-1];
               bids_id[i] = bids_id[i-1];
            end
            bids_price[pos] = price; bids_qty[pos] = qty; bids_id[pos] = oid;
            bids_count++;
         end
         pending_fills.push_back('{KIND_RESTED, oid, oid, price, 24'd0, qty, 1'b1});
      end
   endtask

   // one order transaction: optional gap, then hold start until accepted
   task automatic send_order(input logic sell, input logic [31:0] oid,
                             input logic [15:0] price, input logic [23:0] qty);
      while ($urandom_range(99) < send_gap_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_is_sell <= sell;
      req_order_id <= oid;
      req_order_price <= price;
      req_order_qty <= qty;
      @(posedge clock);
      while (busy) @(posedge clock);
      // accepted at this edge
      match_order(sell, oid, price, qty);
   endtask

   // result checker: compare every strobe with the oldest prediction
   always @(posedge clock) begin
      fill_type want;
      if (!reset && rsp_valid) begin
         if (pending_fills.size() == 0) begin
            report_mismatch("unexpected result", 32'(rsp_kind), 32'd0);
         end else begin
            want = pending_fills.pop_front();
            if (rsp_kind != want.kind)
               report_mismatch("kind", 32'(rsp_kind), 32'(want.kind));
            if (rsp_buy_id != want.buy_id) report_mismatch("buy_id", rsp_buy_id, want.buy_id);
            if (rsp_sell_id != want.sell_id)
               report_mismatch("sell_id", rsp_sell_id, want.sell_id);
            if (rsp_trade_price != want.price)
               report_mismatch("trade_price", 32'(rsp_trade_price), 32'(want.price));
            if (rsp_trade_qty != want.trade_qty)
               report_mismatch("trade_qty", 32'(rsp_trade_qty), 32'(want.trade_qty));
            if (rsp_remaining_qty != want.remaining)
               report_mismatch("remaining_qty", 32'(rsp_remaining_qty),
                               32'(want.remaining));
            if (rsp_last != want.last)
               report_mismatch("last", 32'(rsp_last), 32'(want.last));
         end
      end
   end

   // watchdog: cycles with no accepted transaction on either side
   always @(posedge clock) begin
      if (rsp_valid || (start && !busy)) idle_count <= 0;
      else idle_count <= idle_count + 1;
      if (idle_count >= WATCHDOG_LIMIT) begin
         $display("watchdog timeout at %0t", $time);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // directed: extremes, zero quantity, equal-price time priority, sweeps
   task automatic test_directed();
      send_order(1'b0, 32'h0, 16'h0, 24'h0);            // zero quantity
      send_order(1'b1, 32'hFFFFFFFF, 16'hFFFF, 24'hFFFFFF); // rests as ask
      send_order(1'b0, 32'h1, 16'hFFFF, 24'h1);         // partial fill at max price
      send_order(1'b0, 32'h2, 16'hFFFF, 24'hFFFFFF);    // sweeps rest, rests bid
      send_order(1'b1, 32'h3, 16'h0, 24'h10);           // sells into the bid
      send_order(1'b1, 32'h10, 16'd100, 24'd5);
      send_order(1'b1, 32'h11, 16'd100, 24'd5);          // same price, behind
      send_order(1'b1, 32'h12, 16'd99, 24'd5);           // better price, ahead
      send_order(1'b0, 32'h13, 16'd100, 24'd12);         // one fill against the ask left by 0x3
      send_order(1'b0, 32'h14, 16'd50, 24'd0);
      send_order(1'b1, 32'hA5A5A5A5, 16'h5A5A, 24'h5A5A5A);
      send_order(1'b0, 32'h5A5A5A5A, 16'hA5A5, 24'hA5A5A5);
   endtask

   // fill one side past capacity, then sweep it with one big order
   task automatic test_side_full();
      for (int i = 0; i < BOOK_DEPTH + 3; i++)
         send_order(1'b1, 32'h100 + i, 16'(16'd1000 + $urandom_range(15)),
                    24'(24'd1 + $urandom_range(3)));
      for (int i = 0; i < BOOK_DEPTH + 3; i++)
         send_order(1'b0, 32'h200 + i, 16'(16'd10 + $urandom_range(15)),
                    24'(24'd1 + $urandom_range(3)));
      send_order(1'b0, 32'h300, 16'hFFFF, 24'hFFFFFF);   // no asks left and bid side full: dropped
      send_order(1'b1, 32'h301, 16'h0, 24'hFFFFFF);
   endtask

   // random orders around a narrow mid price so books cross often
   task automatic test_random(input int count);
      logic [15:0] price;
      logic [23:0] qty;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(9))
            0: price = 16'($urandom);
            1: price = $urandom_range(1) ? 16'hFFFF : 16'h0;
            default: price = 16'(16'd32760 + $urandom_range(16));
         endcase
         case ($urandom_range(9))
            0: qty = 24'($urandom);
            1: qty = 24'd0;
            default: qty = 24'(24'd1 + $urandom_range(40));
         endcase
         send_order(1'($urandom_range(1)), $urandom, price, qty);
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_gap_pct = 20;
      test_directed();
      test_side_full();
      test_random(130);
      send_gap_pct = 88;
      test_random(130);
      send_gap_pct = 0;
      test_random(130);
      start <= 1'b0;
      while (pending_fills.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (error_count == 0 && pending_fills.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule
